>>> sv/irpwc_pkg.sv
package irpwc_pkg;

  localparam int unsigned START_TO_W   = 24;
  localparam int unsigned SILENCE_TO_W = 16;
  localparam int unsigned ELAPSED_W    = 24;
  localparam int unsigned WIDTH_W      = 16;
  localparam int unsigned PCOUNT_W     = 11;
  localparam int unsigned CFG_DATA_W   = 24;
  localparam int unsigned CFG_INDEX_W  = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_START_TIMEOUT   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SILENCE_TIMEOUT = 1'd1;

  localparam logic [START_TO_W-1:0]   START_TO_RESET   = 24'd1000000;
  localparam logic [SILENCE_TO_W-1:0] SILENCE_TO_RESET = 16'd50000;

endpackage

>>> sv/ir_pulse_width_capture_core.sv
// Channel   Handshake            Payload
// in        in_valid/in_ready    start_req, pin_level
// out       out_valid/out_ready  has_width, width_ticks, held_level, end_of_capture,
//                                pulse_count, no_start
// cfg       cfg_write            cfg_index, cfg_data
//
// One tick is taken per clock cycle while in_ready is high; its result, if any,
// appears in the output register on the following cycle.
// in_ready stays high while the output register is empty or being emptied, so a
// stalled result holds the input back only while out_ready is low.
// Reset is synchronous and returns the block to idle with the register reset values.
module ir_pulse_width_capture_core #(
  parameter int unsigned MAX_PULSES = 1024
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic                                     start_req,
  input  logic                                     pin_level,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic                                     has_width,
  output logic [irpwc_pkg::WIDTH_W-1:0]            width_ticks,
  output logic                                     held_level,
  output logic                                     end_of_capture,
  output logic [irpwc_pkg::PCOUNT_W-1:0]           pulse_count,
  output logic                                     no_start,
  input  logic                                     cfg_write,
  input  logic [irpwc_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [irpwc_pkg::CFG_DATA_W-1:0]         cfg_data
);

  localparam int unsigned CNT_W = $clog2(MAX_PULSES + 1);
  localparam int unsigned EXT_W = (CNT_W > irpwc_pkg::PCOUNT_W) ? CNT_W : irpwc_pkg::PCOUNT_W;
  localparam int unsigned EL_W  = irpwc_pkg::ELAPSED_W;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_CAPT = 2'd2
  } phase_t;

  phase_t                            phase, phase_next;
  logic                              last_level, last_level_next;
  logic [EL_W-1:0]                   elapsed, elapsed_next;
  logic [CNT_W-1:0]                  count, count_next;
  logic [irpwc_pkg::START_TO_W-1:0]  start_timeout;
  logic [irpwc_pkg::SILENCE_TO_W-1:0] silence_timeout;

  logic                              in_fire;
  logic [EL_W:0]                     diff;
  logic [EL_W-1:0]                   elapsed_sat;
  logic [CNT_W-1:0]                  count_inc;
  logic [EXT_W-1:0]                  count_ext;

  logic                              res_valid;
  logic                              res_has_width;
  logic [irpwc_pkg::WIDTH_W-1:0]     res_width;
  logic                              res_held;
  logic                              res_end;
  logic [CNT_W-1:0]                  res_count;
  logic                              res_no_start;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign diff        = {1'b0, elapsed} + (EL_W+1)'(1);
  assign elapsed_sat = diff[EL_W] ? '1 : diff[EL_W-1:0];
  assign count_inc   = count + CNT_W'(1);

  always_comb begin
    phase_next      = phase;
    last_level_next = last_level;
    elapsed_next    = elapsed;
    count_next      = count;
    res_valid       = 1'b0;
    res_has_width   = 1'b0;
    res_width       = '0;
    res_held        = 1'b0;
    res_end         = 1'b0;
    res_count       = '0;
    res_no_start    = 1'b0;
    unique case (phase)
      PH_WAIT: begin
        if (!pin_level) begin
          phase_next      = PH_CAPT;
          last_level_next = 1'b0;
          elapsed_next    = '0;
        end else if (diff > {1'b0, start_timeout}) begin
          phase_next   = PH_IDLE;
          elapsed_next = '0;
          res_valid    = 1'b1;
          res_end      = 1'b1;
          res_no_start = 1'b1;
        end else begin
          elapsed_next = elapsed_sat;
        end
      end
      PH_CAPT: begin
        if (pin_level != last_level) begin
          count_next      = count_inc;
          last_level_next = pin_level;
          elapsed_next    = '0;
          res_valid       = 1'b1;
          res_has_width   = 1'b1;
          // Intervals longer than the output field report the field's maximum.
          res_width       = (diff > (EL_W+1)'({irpwc_pkg::WIDTH_W{1'b1}}))
                            ? '1 : diff[irpwc_pkg::WIDTH_W-1:0];
          res_held        = last_level;
          res_count       = count_inc;
          if (count_inc >= CNT_W'(MAX_PULSES)) begin
            res_end    = 1'b1;
            phase_next = PH_IDLE;
          end
        end else if (diff > (EL_W+1)'(silence_timeout)) begin
          phase_next   = PH_IDLE;
          elapsed_next = '0;
          res_valid    = 1'b1;
          res_end      = 1'b1;
          res_count    = count;
        end else begin
          elapsed_next = elapsed_sat;
        end
      end
      default: begin
        // Idle, and the unused code, which behaves as idle.
        phase_next = PH_IDLE;
        if (start_req) begin
          count_next      = '0;
          elapsed_next    = '0;
          last_level_next = pin_level;
          phase_next      = pin_level ? PH_WAIT : PH_CAPT;
        end
      end
    endcase
  end

  assign count_ext = EXT_W'(res_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      last_level      <= 1'b1;
      elapsed         <= '0;
      count           <= '0;
      start_timeout   <= irpwc_pkg::START_TO_RESET;
      silence_timeout <= irpwc_pkg::SILENCE_TO_RESET;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == irpwc_pkg::CFG_START_TIMEOUT) begin
          start_timeout <= cfg_data[irpwc_pkg::START_TO_W-1:0];
        end else if (cfg_index == irpwc_pkg::CFG_SILENCE_TIMEOUT) begin
          silence_timeout <= cfg_data[irpwc_pkg::SILENCE_TO_W-1:0];
        end
      end
      if (in_fire) begin
        phase      <= phase_next;
        last_level <= last_level_next;
        elapsed    <= elapsed_next;
        count      <= count_next;
        out_valid  <= res_valid;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      has_width      <= res_has_width;
      width_ticks    <= res_width;
      held_level     <= res_held;
      end_of_capture <= res_end;
      pulse_count    <= count_ext[irpwc_pkg::PCOUNT_W-1:0];
      no_start       <= res_no_start;
    end
  end

endmodule

>>> sv/irpwc_checker.sv
module irpwc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           has_width,
  input logic [irpwc_pkg::WIDTH_W-1:0]  width_ticks,
  input logic                           held_level,
  input logic                           end_of_capture,
  input logic [irpwc_pkg::PCOUNT_W-1:0] pulse_count,
  input logic                           no_start
);

  // A result that is not taken must stay offered, with every field but held_level unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(width_ticks) && $stable(pulse_count)
      && $stable(has_width) && $stable(end_of_capture) && $stable(no_start))
    else $error("result changed while stalled");

  // A failed start carries no interval and closes the capture with a zero count.
  a_no_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_start |-> end_of_capture && !has_width && pulse_count == '0)
    else $error("no-start result malformed");

  // Any result without a measured interval is a timeout and so ends the capture.
  a_timeout: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_width |-> end_of_capture && width_ticks == '0 && !held_level)
    else $error("timeout result malformed");

  // A measured interval is always at least one tick and never counts as a failed start.
  a_width: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_width |-> !no_start && width_ticks != '0 && pulse_count != '0)
    else $error("interval result malformed");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind ir_pulse_width_capture_core irpwc_checker u_irpwc_checker (.*);

>>> sim/ir_pulse_width_capture_core_tb.sv
`timescale 1ns / 100ps

module ir_pulse_width_capture_core_tb;

  localparam int unsigned MAX_PULSES = 1024;
  localparam int unsigned STALL_LIMIT = 4000;

  typedef enum logic [1:0] {CAP_IDLE, CAP_WAIT, CAP_RUN} cap_phase_t;

  typedef struct {
    bit start;
    bit pin;
  } tick_t;

  typedef struct {
    bit                             has_width;
    logic [irpwc_pkg::WIDTH_W-1:0]  width;
    bit                             held;
    bit                             last;
    logic [irpwc_pkg::PCOUNT_W-1:0] count;
    bit                             no_start;
  } pulse_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic                              start_req = 1'b0;
  logic                              pin_level = 1'b0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic                              has_width;
  logic [irpwc_pkg::WIDTH_W-1:0]     width_ticks;
  logic                              held_level;
  logic                              end_of_capture;
  logic [irpwc_pkg::PCOUNT_W-1:0]    pulse_count;
  logic                              no_start;
  logic                              cfg_write = 1'b0;
  logic [irpwc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [irpwc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  // Capture state as the block should hold it.
  cap_phase_t                         cap_phase = CAP_IDLE;
  bit                                 cap_level = 1'b1;
  logic [irpwc_pkg::ELAPSED_W-1:0]    cap_elapsed = '0;
  int unsigned                        cap_count = 0;
  logic [irpwc_pkg::START_TO_W-1:0]   start_limit = irpwc_pkg::START_TO_RESET;
  logic [irpwc_pkg::SILENCE_TO_W-1:0] silence_limit = irpwc_pkg::SILENCE_TO_RESET;

  tick_t       tick_queue[$];
  pulse_t      expected_pulses[$];
  tick_t       next_tick;
  pulse_t      due;
  int unsigned sender_idle_pct = 30;
  int unsigned receiver_idle_pct = 80;
  int unsigned errors = 0;
  int unsigned stall_cycles = 0;
  int unsigned ticks_queued = 0;
  int unsigned widths_seen = 0;
  int unsigned start_timeouts = 0;
  int unsigned silence_timeouts = 0;
  int unsigned full_buffers = 0;
  bit          lvl;

  ir_pulse_width_capture_core #(
    .MAX_PULSES(MAX_PULSES)
  ) uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .start_req      (start_req),
    .pin_level      (pin_level),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .has_width      (has_width),
    .width_ticks    (width_ticks),
    .held_level     (held_level),
    .end_of_capture (end_of_capture),
    .pulse_count    (pulse_count),
    .no_start       (no_start),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic advance_capture(input bit start, input bit pin);
    int unsigned diff;
    pulse_t      res;
    diff = cap_elapsed + 1;
    res = '{1'b0, '0, 1'b0, 1'b1, '0, 1'b0};
    case (cap_phase)
      CAP_WAIT: begin
        if (!pin) begin
          cap_phase = CAP_RUN;
          cap_level = 1'b0;
          cap_elapsed = '0;
        end else if (diff > start_limit) begin
          cap_phase = CAP_IDLE;
          cap_elapsed = '0;
          res.no_start = 1'b1;
          expected_pulses.push_back(res);
          start_timeouts++;
        end else begin
          cap_elapsed = (diff > {irpwc_pkg::ELAPSED_W{1'b1}}) ? {irpwc_pkg::ELAPSED_W{1'b1}}
                        : (irpwc_pkg::ELAPSED_W)'(diff);
        end
      end
      CAP_RUN: begin
        if (pin != cap_level) begin
          cap_count++;
          res.has_width = 1'b1;
          res.width = (diff > {irpwc_pkg::WIDTH_W{1'b1}}) ? {irpwc_pkg::WIDTH_W{1'b1}}
                      : (irpwc_pkg::WIDTH_W)'(diff);
          res.held = cap_level;
          res.last = (cap_count >= MAX_PULSES);
          res.count = (irpwc_pkg::PCOUNT_W)'(cap_count);
          cap_level = pin;
          cap_elapsed = '0;
          widths_seen++;
          if (res.last) begin
            cap_phase = CAP_IDLE;
            full_buffers++;
          end
          expected_pulses.push_back(res);
        end else if (diff > silence_limit) begin
          cap_phase = CAP_IDLE;
          cap_elapsed = '0;
          res.count = (irpwc_pkg::PCOUNT_W)'(cap_count);
          expected_pulses.push_back(res);
          silence_timeouts++;
        end else begin
          cap_elapsed = (diff > {irpwc_pkg::ELAPSED_W{1'b1}}) ? {irpwc_pkg::ELAPSED_W{1'b1}}
                        : (irpwc_pkg::ELAPSED_W)'(diff);
        end
      end
      default: begin
        cap_phase = CAP_IDLE;
        if (start) begin
          cap_count = 0;
          cap_elapsed = '0;
          cap_level = pin;
          cap_phase = pin ? CAP_WAIT : CAP_RUN;
        end
      end
    endcase
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Requests are offered at the clock edge and held until the block takes them.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      start_req <= 1'b0;
      pin_level <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_idle_pct);
      if (!in_valid || in_ready) begin
        if (tick_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_tick = tick_queue.pop_front();
          in_valid <= 1'b1;
          start_req <= next_tick.start;
          pin_level <= next_tick.pin;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      stall_cycles = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pulses.size() == 0) begin
          $display("%0t: result with nothing expected (width %0d, count %0d)",
                   $time, width_ticks, pulse_count);
          errors++;
        end else begin
          due = expected_pulses.pop_front();
          compare_field("has_width", due.has_width, has_width);
          compare_field("width_ticks", due.width, width_ticks);
          compare_field("held_level", due.held, held_level);
          compare_field("end_of_capture", due.last, end_of_capture);
          compare_field("pulse_count", due.count, pulse_count);
          compare_field("no_start", due.no_start, no_start);
        end
      end
      if (in_valid && in_ready)
        advance_capture(start_req, pin_level);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("%0t: no handshake for %0d cycles", $time, stall_cycles);
          $display("ir_pulse_width_capture_core_tb: done, errors");
          $finish;
        end
      end
    end
  end

  task automatic push_tick(input bit start, input bit pin);
    tick_queue.push_back('{start, pin});
    ticks_queued++;
  endtask

  // Upper case is a plain tick, lower case carries a start request; h and l
  // give the line level.
  task automatic queue_pattern(input string pat);
    for (int i = 0; i < pat.len(); i++)
      push_tick(pat[i] == "h" || pat[i] == "l", pat[i] == "H" || pat[i] == "h");
  endtask

  // Each run holds the level for at most max_run ticks, then flips it.
  task automatic queue_edges(input int unsigned n, input int unsigned max_run,
                             inout bit level);
    int unsigned run;
    repeat (n) begin
      run = $urandom_range((max_run == 0) ? 1 : max_run, 1);
      repeat (run - 1) push_tick($urandom_range(7) == 0, level);
      level = ~level;
      push_tick($urandom_range(7) == 0, level);
    end
  endtask

  task automatic queue_capture(input int unsigned st, input int unsigned sil,
                               input int unsigned n_edges, input bit tail);
    bit          level;
    int unsigned hold;
    level = ($urandom_range(3) != 0);
    push_tick(1'b1, level);
    if (level) begin
      // Now and then let the wait for the first low level run out.
      if (st <= 30 && $urandom_range(4) == 0) begin
        repeat (st + 1) push_tick($urandom_range(7) == 0, 1'b1);
        return;
      end
      hold = $urandom_range((st < 30) ? st : 30);
      repeat (hold) push_tick($urandom_range(7) == 0, 1'b1);
      level = 1'b0;
      push_tick($urandom_range(7) == 0, level);
    end
    queue_edges(n_edges, (sil < 25) ? sil : 25, level);
    if (tail)
      repeat (sil + 1) push_tick($urandom_range(7) == 0, level);
  endtask

  task automatic queue_random(input int unsigned n, input int unsigned st,
                              input int unsigned sil);
    int unsigned first;
    first = ticks_queued;
    while (ticks_queued - first < n) begin
      case ($urandom_range(9))
        0: begin
          repeat ($urandom_range(6, 1)) push_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
        end
        1: begin
          push_tick(1'b1, 1'b1);
          repeat ($urandom_range(8, 1)) push_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
        end
        default: begin
          queue_capture(st, sil, $urandom_range(12), $urandom_range(5) != 0);
        end
      endcase
    end
  endtask

  task automatic write_timeouts(input int unsigned st, input int unsigned sil);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= irpwc_pkg::CFG_START_TIMEOUT;
    cfg_data <= (irpwc_pkg::CFG_DATA_W)'(st);
    @(posedge clk);
    cfg_index <= irpwc_pkg::CFG_SILENCE_TIMEOUT;
    cfg_data <= (irpwc_pkg::CFG_DATA_W)'(sil);
    @(posedge clk);
    cfg_write <= 1'b0;
    start_limit = (irpwc_pkg::START_TO_W)'(st);
    silence_limit = (irpwc_pkg::SILENCE_TO_W)'(sil);
    @(negedge clk);
  endtask

  // Drain everything, then close any capture still open so the block is idle.
  task automatic settle_idle;
    bit busy;
    busy = 1'b1;
    while (busy) begin
      while (tick_queue.size() != 0 || in_valid || expected_pulses.size() != 0)
        @(negedge clk);
      if (cap_phase == CAP_WAIT)
        push_tick(1'b0, 1'b0);
      else if (cap_phase == CAP_RUN)
        repeat (silence_limit + 1) push_tick(1'b0, cap_level);
      else
        busy = 1'b0;
    end
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Shortest timeouts: ignored idle ticks, start timeout, low level winning
    // over a timeout, start ignored during capture, silence ends.
    write_timeouts(1, 1);
    queue_pattern("LHhHHhHLHhLLLlHHH");
    settle_idle();
    write_timeouts(0, 0);
    queue_pattern("hHhLHHlL");
    settle_idle();
    write_timeouts(6, 9);
    queue_random(190, 6, 9);
    settle_idle();

    write_timeouts(16777215, 4);
    sender_idle_pct = 80;
    receiver_idle_pct = 30;
    queue_random(190, 16777215, 4);
    settle_idle();
    write_timeouts(13, 25);
    queue_random(190, 13, 25);
    settle_idle();

    // Fill the buffer with an edge on every tick.
    write_timeouts(1000, 3);
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    push_tick(1'b1, 1'b0);
    lvl = 1'b0;
    queue_edges(MAX_PULSES, 1, lvl);
    settle_idle();
    write_timeouts(9, 17);
    queue_random(190, 9, 17);
    settle_idle();

    repeat (8) @(posedge clk);
    if (expected_pulses.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_pulses.size());
      errors++;
    end
    $display("%0d ticks sent: %0d widths, %0d start timeouts, %0d silence timeouts, %0d full",
             ticks_queued, widths_seen, start_timeouts, silence_timeouts, full_buffers);
    $display("timeouts from zero to the full start range under three idling patterns");
    if (errors == 0)
      $display("ir_pulse_width_capture_core_tb: done, clean");
    else
      $display("ir_pulse_width_capture_core_tb: done, errors");
    $finish;
  end

endmodule
